/* rtl/core/fafr_pkg.sv */
// Shared constants, codes and control types for the first-free frame allocator.
`default_nettype none

package fafr_pkg;

  localparam int POOL_FRAMES = 256;
  localparam int FRAME_W     = $clog2(POOL_FRAMES);
  localparam int CNT_W       = 9;
  localparam int OWNER_W     = 8;
  localparam int STATUS_W    = 3;

  localparam logic [CNT_W-1:0]   POOL_CNT = CNT_W'(POOL_FRAMES);
  localparam logic [FRAME_W-1:0] IDX_LAST = FRAME_W'(POOL_FRAMES - 1);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_PLACED    = 3'd0;
  localparam status_t ST_NO_ROOM   = 3'd1;
  localparam status_t ST_ZERO      = 3'd2;
  localparam status_t ST_FREED     = 3'd3;
  localparam status_t ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic start;
    logic alloc_step;
    logic free_step;
    logic load_out;
  } fafr_cmd_t;

  typedef struct packed {
    logic zero_req;
    logic no_room;
    logic free_op;
    logic alloc_done;
    logic scan_last;
  } fafr_stat_t;

endpackage

`default_nettype wire

/* rtl/core/frame_allocator_first_free.sv */
// Top level of the first-free frame allocator over a pool of 256 frames.
// An allocate beat goes from the check state to a scan from frame 0 until it has taken the frames
// wanted; a refused or zero request skips the scan; a free beat scans all 256 frames, then drains.
// The rate is set by the single frame scan, one frame per cycle over the frame flags and owner memory.
// A new beat is taken once the previous result is loaded, even if that result is still stalled.
// Synchronous reset marks every frame free and sets the free count to 256; no clearing pass.
`default_nettype none

module frame_allocator_first_free
  import fafr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_operation,
  input  wire logic [OWNER_W-1:0]  in_owner_id,
  input  wire logic [CNT_W-1:0]    in_frames_wanted,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic [CNT_W-1:0]         out_frames_done,
  output logic [CNT_W-1:0]         out_free_left
);

  fafr_cmd_t  cmd;
  fafr_stat_t stat;

  fafr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  fafr_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_operation     (in_operation),
    .in_owner_id      (in_owner_id),
    .in_frames_wanted (in_frames_wanted),
    .out_status       (out_status),
    .out_frames_done  (out_frames_done),
    .out_free_left    (out_free_left)
  );

  a_left_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_free_left <= POOL_CNT))
    else $error("free frame count exceeds the pool size");

  a_placed_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_PLACED || out_status == ST_FREED)) |->
      (out_frames_done != '0))
    else $error("placed or freed result moved no frames");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_NO_ROOM || out_status == ST_ZERO ||
                   out_status == ST_NOT_FOUND)) |-> (out_frames_done == '0))
    else $error("refused result reports moved frames");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled while a request is in progress");

endmodule

`default_nettype wire

/* rtl/core/fafr_dp.sv */
// Datapath of the frame allocator: frame flags, owner memory, counters and result register.
`default_nettype none

module fafr_dp
  import fafr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fafr_cmd_t          cmd,
  output fafr_stat_t              stat,
  input  wire logic               in_operation,
  input  wire logic [OWNER_W-1:0] in_owner_id,
  input  wire logic [CNT_W-1:0]   in_frames_wanted,
  output logic [STATUS_W-1:0]     out_status,
  output logic [CNT_W-1:0]        out_frames_done,
  output logic [CNT_W-1:0]        out_free_left
);

  logic [POOL_FRAMES-1:0] in_use_r;
  logic [CNT_W-1:0]       free_cnt_r;
  logic                   rd_vld_r;

  logic                   op_r;
  logic [OWNER_W-1:0]     who_r;
  logic [CNT_W-1:0]       want_r;
  logic [CNT_W-1:0]       got_r;
  logic [FRAME_W-1:0]     idx_r;
  logic [FRAME_W-1:0]     rd_idx_r;
  logic                   rd_used_r;
  logic [OWNER_W-1:0]     rd_owner_r;

  logic [OWNER_W-1:0]     owner_mem [POOL_FRAMES];

  status_t                status_r;
  logic [CNT_W-1:0]       done_r;
  logic [CNT_W-1:0]       left_r;

  logic                   take;
  logic                   hit;
  status_t                status_nxt;
  logic [CNT_W-1:0]       done_nxt;

  assign take = cmd.alloc_step && !in_use_r[idx_r];
  assign hit  = rd_vld_r && rd_used_r && (rd_owner_r == who_r);

  assign stat.zero_req   = (want_r == '0);
  assign stat.no_room    = (want_r > free_cnt_r);
  assign stat.free_op    = (op_r == OP_FREE);
  assign stat.alloc_done = (got_r == want_r);
  assign stat.scan_last  = (idx_r == IDX_LAST);

  always_comb begin
    status_nxt = ST_PLACED;
    done_nxt   = got_r;
    if (op_r == OP_FREE) begin
      status_nxt = (got_r == '0) ? ST_NOT_FOUND : ST_FREED;
    end else if (want_r == '0) begin
      status_nxt = ST_ZERO;
      done_nxt   = '0;
    end else if (got_r == '0) begin
      // A refused request never takes a frame, so an empty count marks it.
      status_nxt = ST_NO_ROOM;
      done_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r   <= '0;
      free_cnt_r <= POOL_CNT;
      rd_vld_r   <= 1'b0;
    end else begin
      if (take) begin
        in_use_r[idx_r] <= 1'b1;
        free_cnt_r      <= free_cnt_r - CNT_W'(1);
      end
      if (hit) begin
        in_use_r[rd_idx_r] <= 1'b0;
        free_cnt_r         <= free_cnt_r + CNT_W'(1);
      end
      rd_vld_r <= cmd.free_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r   <= in_operation;
      who_r  <= in_owner_id;
      want_r <= in_frames_wanted;
      got_r  <= '0;
      idx_r  <= '0;
    end else begin
      if (cmd.alloc_step || cmd.free_step) begin
        idx_r <= idx_r + FRAME_W'(1);
      end
      if (take || hit) begin
        got_r <= got_r + CNT_W'(1);
      end
    end
    if (cmd.free_step) begin
      rd_idx_r  <= idx_r;
      rd_used_r <= in_use_r[idx_r];
    end
    if (cmd.load_out) begin
      status_r <= status_nxt;
      done_r   <= done_nxt;
      left_r   <= free_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      owner_mem[idx_r] <= who_r;
    end
    if (cmd.free_step) begin
      rd_owner_r <= owner_mem[idx_r];
    end
  end

  assign out_status      = status_r;
  assign out_frames_done = done_r;
  assign out_free_left   = left_r;

endmodule

`default_nettype wire

/* rtl/core/fafr_ctrl.sv */
// Controller of the frame allocator: request sequencing and handshake control.
`default_nettype none

module fafr_ctrl
  import fafr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire fafr_stat_t stat,
  output fafr_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ALLOC,
    S_FREE,
    S_DRAIN,
    S_RESULT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_stall_r;
  logic   in_stall_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    in_stall_nxt  = in_stall_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start    = 1'b1;
          in_stall_nxt = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.free_op) begin
          state_nxt = S_FREE;
        end else if (stat.zero_req || stat.no_room) begin
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (stat.alloc_done) begin
          state_nxt = S_RESULT;
        end else begin
          cmd.alloc_step = 1'b1;
        end
      end
      S_FREE: begin
        cmd.free_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          in_stall_nxt  = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_stall_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_stall_r  <= in_stall_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
